// File: hw/rtl/til_pkg.sv
// ----------------------------------------------------------------------------
// til_pkg: shared types and constants for the interpolation lookup
// Field layout of the stream beats, datapath widths and sequencer states.
// ----------------------------------------------------------------------------
package til_pkg;

    // Value and field widths.
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 7;
    localparam int REACH   = 2 ** IDX_W;

    // Input beat layout, first field in the lowest bits, padded to bytes.
    localparam int IDX_LSB = 0;
    localparam int BPX_LSB = IDX_LSB + IDX_W;
    localparam int BPY_LSB = BPX_LSB + DATA_W;
    localparam int QX_LSB  = BPY_LSB + DATA_W;
    localparam int S_USED  = QX_LSB + DATA_W;
    localparam int S_DATA_W = ((S_USED + 7) / 8) * 8;

    // Output sideband bits.
    localparam int FLAG_CLAMP = 0;
    localparam int FLAG_DEGEN = 1;
    localparam int M_USER_W   = 2;

    // Shared add/subtract unit and step counter.
    localparam int ALU_W = DATA_W + 3;
    localparam int CNT_W = $clog2(DATA_W);
    localparam int PROD_W = 2 * DATA_W;

    // Beat kinds.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Saturation limits.
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Sequencer states.
    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_FIRST  = 15'b000000000000010,
        S_LAST   = 15'b000000000000100,
        S_SEEK   = 15'b000000000001000,
        S_PROBE  = 15'b000000000010000,
        S_FETCH1 = 15'b000000000100000,
        S_FETCH2 = 15'b000000001000000,
        S_DX     = 15'b000000010000000,
        S_DXS    = 15'b000000100000000,
        S_DY     = 15'b000001000000000,
        S_MUL    = 15'b000010000000000,
        S_CHK    = 15'b000100000000000,
        S_DIV    = 15'b001000000000000,
        S_SUM    = 15'b010000000000000,
        S_EMIT   = 15'b100000000000000
    } state_t;

endpackage

// File: hw/rtl/table_interpolation_lookup.sv
// ----------------------------------------------------------------------------
// table_interpolation_lookup: piecewise linear interpolation in a breakpoint table
// Write beats store (x, y) pairs; lookup beats clamp the query, binary search
// the bracketing pair and return y1 + (xs-x1)*(y2-y1)/(x2-x1), saturated.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata {query_x, breakpoint_y, breakpoint_x, entry_index}
//                                   tuser op (0 write pair, 1 lookup)
// m_*       out  m_tvalid/m_tready  tdata result_y; tuser {degenerate_pair, was_clamped}
// cfg_*     in   cfg_wen            entries_in_use, no read-back
//
// A lookup makes P search probes, at most ceil(log2(n-1)); when the quotient
// saturates it skips the divide, and for equal abscissas it skips both the
// multiply and the divide. The 32-step multiply and the 32-step restoring divide
// share the one add/subtract unit; the tables have one read port each.
// s_tready is high only while the sequencer is idle. A finished result waits in
// the output register, so new beats are taken while m_tready is low.
// Reset clears control state and sets entries_in_use to 2; tables are not cleared.

module table_interpolation_lookup
    import til_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write.
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_wdata,    // entries_in_use
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,      // entry_index[5:0], breakpoint_x[37:6],
                                              // breakpoint_y[69:38], query_x[101:70]
    input  logic                s_tuser,      // op
    // Output stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,      // result_y[31:0]
    output logic [M_USER_W-1:0] m_tuser       // was_clamped[0], degenerate_pair[1]
);

    localparam int LIM = (TABLE_DEPTH < REACH) ? TABLE_DEPTH : REACH;
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW  = (LIM > 1) ? $clog2(LIM) : 1;

    // Breakpoint memories.
    logic [DATA_W-1:0] x_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] y_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] x_rd_reg;
    logic [DATA_W-1:0] y_rd_reg;
    logic [AW-1:0]     x_addr;
    logic [AW-1:0]     y_addr;
    logic              wr_en;

    // Control and datapath registers.
    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   cfg_reg, cfg_next;
    logic [IW-1:0]      bot_reg, bot_next;
    logic [IW-1:0]      top_reg, top_next;
    logic [IW-1:0]      mid_reg, mid_next;
    logic [DATA_W-1:0]  xq_reg, xq_next;
    logic [DATA_W-1:0]  xs_reg, xs_next;
    logic [DATA_W-1:0]  xbot_reg, xbot_next;
    logic [DATA_W-1:0]  x2_reg, x2_next;
    logic [DATA_W-1:0]  y1_reg, y1_next;
    logic [DATA_W-1:0]  y2_reg, y2_next;
    logic [DATA_W-1:0]  d_reg, d_next;
    logic [DATA_W-1:0]  mcand_reg, mcand_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               big_reg, big_next;
    logic               clamp_reg, clamp_next;
    logic               degen_reg, degen_next;
    logic [DATA_W-1:0]  res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_y_reg, out_y_next;
    logic               out_clamp_reg, out_clamp_next;
    logic               out_degen_reg, out_degen_next;

    // Shared add/subtract unit.
    logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
    logic               alu_sub;

    // Difference operands for the magnitude steps.
    logic [DATA_W-1:0]  diff_p, diff_q;
    logic               diff_lt;

    logic [CFG_W-1:0]   n_eff;
    logic [IW-1:0]      top_init;
    logic [IW-1:0]      mid_calc;
    logic               wr_in_range;
    logic               probe_hit;
    logic               sat_ok;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_y_reg;
    assign m_tuser  = {out_degen_reg, out_clamp_reg};

    // Effective entry count and initial search bounds.
    always_comb
    begin
        if (cfg_reg < CFG_W'(2))
            n_eff = CFG_W'(2);
        else if (cfg_reg > CFG_W'(LIM))
            n_eff = CFG_W'(LIM);
        else
            n_eff = cfg_reg;
    end
    assign top_init = IW'(n_eff - CFG_W'(1));
    assign mid_calc = bot_reg + ((top_reg - bot_reg) >> 1);

    assign wr_in_range = int'(s_tdata[IDX_LSB +: IDX_W]) < TABLE_DEPTH;
    assign wr_en = (state_reg == S_IDLE) && s_tvalid && (s_tuser == OP_WRITE) && wr_in_range;

    // Search test: the query lies within [x[bot], x[mid]].
    assign probe_hit = ($signed(xbot_reg) <= $signed(xs_reg))
                    && ($signed(xs_reg) <= $signed(x_rd_reg));

    // Memory read addresses.
    always_comb
    begin
        x_addr = '0;
        y_addr = '0;
        case (state_reg)
            S_FIRST:
            begin
                x_addr = AW'(top_reg);
            end
            S_SEEK:
            begin
                x_addr = ((top_reg - bot_reg) > IW'(1)) ? AW'(mid_calc) : AW'(top_reg);
                y_addr = AW'(bot_reg);
            end
            S_FETCH1:
            begin
                y_addr = AW'(top_reg);
            end
            default:
            begin
                x_addr = '0;
                y_addr = '0;
            end
        endcase
    end

    // Breakpoint memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[AW'(s_tdata[IDX_LSB +: IDX_W])] <= s_tdata[BPX_LSB +: DATA_W];
            y_mem[AW'(s_tdata[IDX_LSB +: IDX_W])] <= s_tdata[BPY_LSB +: DATA_W];
        end
        x_rd_reg <= x_mem[x_addr];
        y_rd_reg <= y_mem[y_addr];
    end

    // Operand pair for the signed difference steps.
    always_comb
    begin
        case (state_reg)
            S_DXS:
            begin
                diff_p = xs_reg;
                diff_q = xbot_reg;
            end
            S_DY:
            begin
                diff_p = y2_reg;
                diff_q = y1_reg;
            end
            default:
            begin
                diff_p = x2_reg;
                diff_q = xbot_reg;
            end
        endcase
    end
    assign diff_lt = $signed(diff_p) < $signed(diff_q);

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_DX, S_DXS, S_DY:
            begin
                // Larger minus smaller gives the magnitude.
                alu_a   = diff_lt ? {{3{diff_q[DATA_W-1]}}, diff_q}
                                  : {{3{diff_p[DATA_W-1]}}, diff_p};
                alu_b   = diff_lt ? {{3{diff_p[DATA_W-1]}}, diff_p}
                                  : {{3{diff_q[DATA_W-1]}}, diff_q};
                alu_sub = 1'b1;
            end
            S_MUL:
            begin
                alu_a = {3'b000, prod_reg[PROD_W-1:DATA_W]};
                alu_b = prod_reg[0] ? {3'b000, mcand_reg} : '0;
            end
            S_CHK:
            begin
                alu_a   = {3'b000, prod_reg[PROD_W-1:DATA_W]};
                alu_b   = {3'b000, d_reg};
                alu_sub = 1'b1;
            end
            S_DIV:
            begin
                alu_a   = {2'b00, prod_reg[PROD_W-1:DATA_W-1]};
                alu_b   = {3'b000, d_reg};
                alu_sub = 1'b1;
            end
            S_SUM:
            begin
                alu_a   = {{3{y1_reg[DATA_W-1]}}, y1_reg};
                alu_b   = {3'b000, prod_reg[DATA_W-1:0]};
                alu_sub = neg_reg;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end
    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

    // The sum fits when its top bits are all copies of the sign.
    assign sat_ok = (alu_sum[ALU_W-1:DATA_W-1] == '0) || (alu_sum[ALU_W-1:DATA_W-1] == '1);

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_wen ? cfg_wdata : cfg_reg;
        bot_next       = bot_reg;
        top_next       = top_reg;
        mid_next       = mid_reg;
        xq_next        = xq_reg;
        xs_next        = xs_reg;
        xbot_next      = xbot_reg;
        x2_next        = x2_reg;
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        d_next         = d_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        big_next       = big_reg;
        clamp_next     = clamp_reg;
        degen_next     = degen_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_y_next     = out_y_reg;
        out_clamp_next = out_clamp_reg;
        out_degen_next = out_degen_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Lookup beats start the sequencer; x[0] is read meanwhile.
                if (s_tvalid && (s_tuser == OP_LOOKUP))
                begin
                    xq_next    = s_tdata[QX_LSB +: DATA_W];
                    bot_next   = '0;
                    top_next   = top_init;
                    clamp_next = 1'b0;
                    degen_next = 1'b0;
                    big_next   = 1'b0;
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                xbot_next  = x_rd_reg;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                // Clamp the query to the table range.
                if ($signed(xq_reg) < $signed(xbot_reg))
                begin
                    xs_next    = xbot_reg;
                    clamp_next = 1'b1;
                end
                else if ($signed(xq_reg) > $signed(x_rd_reg))
                begin
                    xs_next    = x_rd_reg;
                    clamp_next = 1'b1;
                end
                else
                begin
                    xs_next = xq_reg;
                end
                state_next = S_SEEK;
            end
            S_SEEK:
            begin
                if ((top_reg - bot_reg) > IW'(1))
                begin
                    mid_next   = mid_calc;
                    state_next = S_PROBE;
                end
                else
                begin
                    state_next = S_FETCH1;
                end
            end
            S_PROBE:
            begin
                if (probe_hit)
                begin
                    top_next = mid_reg;
                end
                else
                begin
                    bot_next  = mid_reg;
                    xbot_next = x_rd_reg;
                end
                state_next = S_SEEK;
            end
            S_FETCH1:
            begin
                x2_next    = x_rd_reg;
                y1_next    = y_rd_reg;
                state_next = S_FETCH2;
            end
            S_FETCH2:
            begin
                y2_next    = y_rd_reg;
                state_next = S_DX;
            end
            S_DX:
            begin
                d_next   = alu_sum[DATA_W-1:0];
                neg_next = diff_lt;
                if (x2_reg == xbot_reg)
                begin
                    // Equal abscissas: return y1 unchanged.
                    res_next   = y1_reg;
                    degen_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DXS;
                end
            end
            S_DXS:
            begin
                prod_next  = {{DATA_W{1'b0}}, alu_sum[DATA_W-1:0]};
                neg_next   = neg_reg ^ diff_lt;
                state_next = S_DY;
            end
            S_DY:
            begin
                mcand_next = alu_sum[DATA_W-1:0];
                neg_next   = neg_reg ^ diff_lt;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // Shift-add multiply, one multiplier bit a step.
                prod_next = {alu_sum[DATA_W:0], prod_reg[DATA_W-1:1]};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1))
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                // A high half at or above the divisor means the quotient overflows.
                cnt_next = '0;
                if (!alu_sum[ALU_W-1])
                begin
                    big_next   = 1'b1;
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring divide, remainder in the high half, quotient into the low half.
                prod_next = {(!alu_sum[ALU_W-1]) ? alu_sum[DATA_W-1:0]
                                                 : prod_reg[PROD_W-2:DATA_W-1],
                             prod_reg[DATA_W-2:0], !alu_sum[ALU_W-1]};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1))
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                if (big_reg)
                    res_next = neg_reg ? SAT_MIN : SAT_MAX;
                else if (sat_ok)
                    res_next = alu_sum[DATA_W-1:0];
                else
                    res_next = alu_sum[ALU_W-1] ? SAT_MIN : SAT_MAX;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_y_next     = res_reg;
                    out_clamp_next = clamp_reg;
                    out_degen_next = degen_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= CFG_W'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        bot_reg       <= bot_next;
        top_reg       <= top_next;
        mid_reg       <= mid_next;
        xq_reg        <= xq_next;
        xs_reg        <= xs_next;
        xbot_reg      <= xbot_next;
        x2_reg        <= x2_next;
        y1_reg        <= y1_next;
        y2_reg        <= y2_next;
        d_reg         <= d_next;
        mcand_reg     <= mcand_next;
        prod_reg      <= prod_next;
        cnt_reg       <= cnt_next;
        neg_reg       <= neg_next;
        big_reg       <= big_next;
        clamp_reg     <= clamp_next;
        degen_reg     <= degen_next;
        res_reg       <= res_next;
        out_y_reg     <= out_y_next;
        out_clamp_reg <= out_clamp_next;
        out_degen_reg <= out_degen_next;
    end

endmodule
